/* sv/rcfd_pkg.sv */
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared constants, codes and types of the remote-control frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  localparam int BUFFER_BYTES = 36;
  localparam int FRAME_BYTES  = 18;
  localparam int LEN_W        = $clog2(BUFFER_BYTES + 1);
  localparam int POS_W        = $clog2(FRAME_BYTES);
  localparam int CHAN_W       = 12;
  localparam int RAW_W        = 11;
  localparam int AXIS_W       = 16;
  localparam int SWB_W        = 20;
  localparam int TMO_W        = 16;
  localparam int TICK_W       = TMO_W + 1;
  localparam int CFG_W        = 16;

  localparam logic [RAW_W-1:0] MIDPOINT_RST = 11'd1024;
  localparam logic [TMO_W-1:0] TIMEOUT_RST  = 16'd100;

  // request codes
  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_IDLE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // configuration register indexes
  localparam logic REG_MIDPOINT = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  typedef enum logic [1:0] {
    STAT_NONE = 2'd0,
    STAT_GOOD = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic done;        // burst ends on this word
    logic have_frame;  // a complete frame exists in this burst
  } burst_ev_t;

  typedef struct packed {
    logic [4:0][CHAN_W-1:0] chan;
    logic [SWB_W-1:0]       sw_btn;
    logic [2:0][AXIS_W-1:0] mouse;
    logic [AXIS_W-1:0]      keys;
  } record_t;

endpackage

/* sv/rcfd_frame_asm.sv */
// ----------------------------------------------------------------------------
// rcfd_frame_asm
// Burst byte counter and aligned frame assembly; presents the last complete
// frame of the burst when the burst ends.
// ----------------------------------------------------------------------------
module rcfd_frame_asm (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [1:0]         req_type,
  input  logic [7:0]         data_byte,
  output rcfd_pkg::burst_ev_t ev,
  output rcfd_pkg::frame_t   frame
);
  import rcfd_pkg::*;

  logic [LEN_W-1:0]               len_r, len_nxt;
  logic [POS_W-1:0]               pos_r, pos_nxt;
  logic                           have_r, have_nxt;
  logic [FRAME_BYTES-2:0][7:0]    cur_r;
  frame_t                         last_r;
  frame_t                         new_frame;
  logic                           is_byte, is_idle, completes, full;

  always_comb begin
    is_byte   = step && (req_type == REQ_BYTE);
    is_idle   = step && (req_type == REQ_IDLE);
    completes = is_byte && (pos_r == POS_W'(FRAME_BYTES - 1));
    full      = is_byte && (len_r == LEN_W'(BUFFER_BYTES - 1));
    new_frame = {data_byte, cur_r};

    ev.done       = full || (is_idle && (len_r != '0));
    ev.have_frame = completes || have_r;
    frame         = completes ? new_frame : last_r;

    len_nxt  = len_r;
    pos_nxt  = pos_r;
    have_nxt = have_r;
    if (ev.done) begin
      len_nxt  = '0;
      pos_nxt  = '0;
      have_nxt = 1'b0;
    end else if (is_byte) begin
      len_nxt  = len_r + 1'b1;
      pos_nxt  = completes ? '0 : pos_r + 1'b1;
      have_nxt = have_r || completes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      pos_r  <= '0;
      have_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      pos_r  <= pos_nxt;
      have_r <= have_nxt;
    end
  end

  // frame bytes carry no reset
  always_ff @(posedge clk) begin
    if (is_byte && !completes) begin
      cur_r[pos_r] <= data_byte;
    end
    if (completes) begin
      last_r <= new_frame;
    end
  end

endmodule

/* sv/rcfd_decode.sv */
// ----------------------------------------------------------------------------
// rcfd_decode
// Bit slicing of one 18-byte frame into channels, switches, mouse and keys.
// ----------------------------------------------------------------------------
module rcfd_decode (
  input  rcfd_pkg::frame_t           frame,
  input  logic [rcfd_pkg::RAW_W-1:0] midpoint,
  output logic                       good,
  output rcfd_pkg::record_t          rec
);
  import rcfd_pkg::*;

  logic [4:0][RAW_W-1:0] raw;
  logic [1:0]            sa, sb;

  always_comb begin
    sa   = frame[5][5:4];
    sb   = frame[5][7:6];
    good = (sa != 2'd0) && (sb != 2'd0);

    raw[0] = {frame[1][2:0], frame[0]};
    raw[1] = {frame[2][5:0], frame[1][7:3]};
    raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
    raw[3] = {frame[5][3:0], frame[4][7:1]};
    raw[4] = {frame[17][2:0], frame[16]};

    for (int i = 0; i < 5; i++) begin
      rec.chan[i] = {1'b0, raw[i]} - {1'b0, midpoint};
    end
    rec.sw_btn   = {frame[13], frame[12], sb, sa};
    rec.mouse[0] = {frame[7], frame[6]};
    rec.mouse[1] = {frame[9], frame[8]};
    rec.mouse[2] = {frame[11], frame[10]};
    rec.keys     = {frame[15], frame[14]};
  end

endmodule

/* sv/rc_receiver_frame_decoder.sv */
// ----------------------------------------------------------------------------
// rc_receiver_frame_decoder
// Remote-control receiver: gathers 18-byte frames, holds the decoded record
// and reports an online flag.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one word per received byte,
// line-idle event or 1 ms tick. Every accepted word produces exactly one
// result word on the out_ channel: a status code (none, good frame, rejected
// frame), the online flag and the held record of channels, switches,
// buttons, mouse axes and key mask.
// From the accepting edge a word passes one input register, then the decode
// and state update land in the output register. Throughput is one word per
// cycle while out_ready stays high; the output register and the input
// register let a new word enter while a result waits, so a stalled receiver
// backs up at most two words before in_ready drops.
// Reset clears the burst counter, held record and tick count (the online
// register has no reset; it follows the cleared count) and loads midpoint
// 1024 and timeout 100. No clearing pass is needed: frame bytes are only
// read after being written. cfg_we writes channel_midpoint (index 0) or
// online_timeout (index 1) at once; write only while the block is idle.
// ----------------------------------------------------------------------------
module rc_receiver_frame_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_req_type,
  input  logic [7:0]                          in_data_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic                                out_online,
  output logic signed [rcfd_pkg::CHAN_W-1:0]  out_channel_0,
  output logic signed [rcfd_pkg::CHAN_W-1:0]  out_channel_1,
  output logic signed [rcfd_pkg::CHAN_W-1:0]  out_channel_2,
  output logic signed [rcfd_pkg::CHAN_W-1:0]  out_channel_3,
  output logic signed [rcfd_pkg::CHAN_W-1:0]  out_channel_4,
  output logic [rcfd_pkg::SWB_W-1:0]          out_switches_and_buttons,
  output logic signed [rcfd_pkg::AXIS_W-1:0]  out_mouse_x,
  output logic signed [rcfd_pkg::AXIS_W-1:0]  out_mouse_y,
  output logic signed [rcfd_pkg::AXIS_W-1:0]  out_mouse_z,
  output logic [rcfd_pkg::AXIS_W-1:0]         out_key_mask,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [rcfd_pkg::CFG_W-1:0]          cfg_wdata
);
  import rcfd_pkg::*;

  logic               s1_valid_r;
  logic [1:0]         s1_req_r;
  logic [7:0]         s1_byte_r;
  logic               out_valid_r;
  status_t            status_r, status_nxt;
  logic               online_r, online_nxt;
  record_t            held_r, held_nxt;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt;
  logic [RAW_W-1:0]   midpoint_r;
  logic [TMO_W-1:0]   timeout_r;

  logic               out_free, step;
  burst_ev_t          ev;
  frame_t             frame;
  logic               frame_ok, good_frame;
  record_t            dec_rec;

  assign out_free = !out_valid_r || out_ready;
  assign step     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || step;

  rcfd_frame_asm u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .req_type  (s1_req_r),
    .data_byte (s1_byte_r),
    .ev        (ev),
    .frame     (frame)
  );

  rcfd_decode u_dec (
    .frame    (frame),
    .midpoint (midpoint_r),
    .good     (frame_ok),
    .rec      (dec_rec)
  );

  always_comb begin
    good_frame = ev.done && ev.have_frame && frame_ok;
    if (!ev.done) begin
      status_nxt = STAT_NONE;
    end else if (good_frame) begin
      status_nxt = STAT_GOOD;
    end else begin
      status_nxt = STAT_BAD;
    end

    held_nxt = good_frame ? dec_rec : held_r;

    ticks_nxt = ticks_r;
    if (good_frame) begin
      ticks_nxt = '0;
    end else if (step && (s1_req_r == REQ_TICK) && (ticks_r <= {1'b0, timeout_r})) begin
      ticks_nxt = ticks_r + 1'b1;
    end
    online_nxt = (ticks_nxt <= {1'b0, timeout_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      held_r      <= '0;
      ticks_r     <= '0;
      midpoint_r  <= MIDPOINT_RST;
      timeout_r   <= TIMEOUT_RST;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (step) begin
        held_r  <= held_nxt;
        ticks_r <= ticks_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIDPOINT: midpoint_r <= cfg_wdata[RAW_W-1:0];
          REG_TIMEOUT:  timeout_r  <= cfg_wdata[TMO_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_r  <= in_req_type;
      s1_byte_r <= in_data_byte;
    end
    if (step) begin
      status_r <= status_nxt;
      online_r <= online_nxt;
    end
  end

  record_t out_rec_r;
  always_ff @(posedge clk) begin
    if (step) begin
      out_rec_r <= held_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_status               = status_r;
  assign out_online               = online_r;
  assign out_channel_0            = out_rec_r.chan[0];
  assign out_channel_1            = out_rec_r.chan[1];
  assign out_channel_2            = out_rec_r.chan[2];
  assign out_channel_3            = out_rec_r.chan[3];
  assign out_channel_4            = out_rec_r.chan[4];
  assign out_switches_and_buttons = out_rec_r.sw_btn;
  assign out_mouse_x              = out_rec_r.mouse[0];
  assign out_mouse_y              = out_rec_r.mouse[1];
  assign out_mouse_z              = out_rec_r.mouse[2];
  assign out_key_mask             = out_rec_r.keys;

  // a good frame restarts the tick count, so the link reads online
  a_good_online: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == STAT_GOOD) |-> online_r)
    else $error("good frame reported offline");

  // a good frame never carries a zero switch
  a_good_switches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == STAT_GOOD) |->
      (out_rec_r.sw_btn[1:0] != 2'd0) && (out_rec_r.sw_btn[3:2] != 2'd0))
    else $error("good frame with zero switch");

  // hold the input register while the output side stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !step |=> s1_valid_r && $stable(s1_req_r) && $stable(s1_byte_r))
    else $error("input register lost a stalled word");

  // a rejected or empty word leaves the held record alone
  a_record_kept: assert property (@(posedge clk) disable iff (!rst_n)
    step && (status_nxt != STAT_GOOD) |=> $stable(held_r))
    else $error("held record changed without a good frame");

endmodule

/* bench/rcfd_checker.sv */
// ----------------------------------------------------------------------------
// rcfd_checker
// Watches both channels and the register port of the frame decoder. It keeps
// its own copy of the burst buffer, held record and tick count, predicts one
// result word per accepted input word and compares each result word, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rcfd_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [1:0]                         in_req_type,
  input  logic [7:0]                         in_data_byte,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [1:0]                         out_status,
  input  logic                               out_online,
  input  logic signed [rcfd_pkg::CHAN_W-1:0] out_channel_0,
  input  logic signed [rcfd_pkg::CHAN_W-1:0] out_channel_1,
  input  logic signed [rcfd_pkg::CHAN_W-1:0] out_channel_2,
  input  logic signed [rcfd_pkg::CHAN_W-1:0] out_channel_3,
  input  logic signed [rcfd_pkg::CHAN_W-1:0] out_channel_4,
  input  logic [rcfd_pkg::SWB_W-1:0]         out_switches_and_buttons,
  input  logic signed [rcfd_pkg::AXIS_W-1:0] out_mouse_x,
  input  logic signed [rcfd_pkg::AXIS_W-1:0] out_mouse_y,
  input  logic signed [rcfd_pkg::AXIS_W-1:0] out_mouse_z,
  input  logic [rcfd_pkg::AXIS_W-1:0]        out_key_mask,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [rcfd_pkg::CFG_W-1:0]         cfg_wdata,
  output int                                 err_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rcfd_pkg::*;

  typedef struct packed {
    status_t status;
    logic    online;
    record_t rec;
  } decoded_word_t;

  logic [7:0]        burst_bytes [BUFFER_BYTES];
  int unsigned       burst_len;
  record_t           held_rec;
  logic [TICK_W-1:0] ticks_good;
  logic [RAW_W-1:0]  midpoint;
  logic [TMO_W-1:0]  timeout;
  decoded_word_t     decoded_q [$];
  decoded_word_t     oldest;

  function automatic logic [CHAN_W-1:0] centered(input logic [31:0] raw);
    return {1'b0, raw[RAW_W-1:0]} - {1'b0, midpoint};
  endfunction

  // Close the burst of n bytes and decode its last aligned frame.
  function automatic status_t close_burst(input int unsigned n);
    int unsigned base;
    logic [7:0]  b [FRAME_BYTES];
    logic [1:0]  sw1, sw2;
    burst_len = 0;
    if (n < FRAME_BYTES) return STAT_BAD;
    base = n - (n % FRAME_BYTES) - FRAME_BYTES;
    for (int i = 0; i < FRAME_BYTES; i++) b[i] = burst_bytes[base + i];
    sw1 = b[5][5:4];
    sw2 = b[5][7:6];
    if (sw1 == 2'd0 || sw2 == 2'd0) return STAT_BAD;
    held_rec.chan[0] = centered({b[1], b[0]});
    held_rec.chan[1] = centered({b[2], b[1]} >> 3);
    held_rec.chan[2] = centered({b[4], b[3], b[2]} >> 6);
    held_rec.chan[3] = centered({b[5], b[4]} >> 1);
    held_rec.chan[4] = centered({b[17], b[16]});
    held_rec.sw_btn = {b[13], b[12], sw2, sw1};
    held_rec.mouse[0] = {b[7], b[6]};
    held_rec.mouse[1] = {b[9], b[8]};
    held_rec.mouse[2] = {b[11], b[10]};
    held_rec.keys = {b[15], b[14]};
    ticks_good = '0;
    return STAT_GOOD;
  endfunction

  function automatic decoded_word_t decode_word(input logic [1:0] req, input logic [7:0] data);
    decoded_word_t res;
    res.status = STAT_NONE;
    case (req)
      REQ_BYTE: begin
        if (burst_len < BUFFER_BYTES) begin
          burst_bytes[burst_len] = data;
          burst_len++;
        end
        if (burst_len >= BUFFER_BYTES) res.status = close_burst(burst_len);
      end
      REQ_IDLE: begin
        if (burst_len != 0) res.status = close_burst(burst_len);
      end
      REQ_TICK: begin
        // saturate one past the timeout
        if (ticks_good <= timeout) ticks_good++;
      end
      default: ;
    endcase
    res.online = (ticks_good <= timeout);
    res.rec = held_rec;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0d ns: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      burst_len = 0;
      held_rec = '0;
      ticks_good = '0;
      midpoint = MIDPOINT_RST;
      timeout = TIMEOUT_RST;
      decoded_q.delete();
      err_count = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MIDPOINT) midpoint = cfg_wdata[RAW_W-1:0];
        else timeout = cfg_wdata[TMO_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          err_count++;
          $display("%0d ns: result word with nothing expected, actual status %0d",
                   $time, out_status);
        end else begin
          oldest = decoded_q.pop_front();
          check_field("status", oldest.status, out_status);
          check_field("online", oldest.online, out_online);
          check_field("channel_0", oldest.rec.chan[0], $unsigned(out_channel_0));
          check_field("channel_1", oldest.rec.chan[1], $unsigned(out_channel_1));
          check_field("channel_2", oldest.rec.chan[2], $unsigned(out_channel_2));
          check_field("channel_3", oldest.rec.chan[3], $unsigned(out_channel_3));
          check_field("channel_4", oldest.rec.chan[4], $unsigned(out_channel_4));
          check_field("switches_and_buttons", oldest.rec.sw_btn, out_switches_and_buttons);
          check_field("mouse_x", oldest.rec.mouse[0], $unsigned(out_mouse_x));
          check_field("mouse_y", oldest.rec.mouse[1], $unsigned(out_mouse_y));
          check_field("mouse_z", oldest.rec.mouse[2], $unsigned(out_mouse_z));
          check_field("key_mask", oldest.rec.keys, out_key_mask);
        end
      end
      if (in_valid && in_ready) decoded_q.push_back(decode_word(in_req_type, in_data_byte));
      pending = decoded_q.size();
    end
  end

endmodule

/* bench/tb_rc_receiver_frame_decoder.sv */
// ----------------------------------------------------------------------------
// tb_rc_receiver_frame_decoder
// Drives the frame decoder with bytes, idle events and ticks: a short
// directed opening, then phases of random bursts under changing midpoint and
// timeout settings, with bursty sending and a stalling receiver. The checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_rc_receiver_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import rcfd_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 8;
  localparam int WORDS_PER_PHASE = 75;
  localparam int END_CYCLES     = 8;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_SETTING = -1;

  // phase 0 runs on reset values
  localparam int MID_SET [PHASES] = '{1024, 0, 2047, RANDOM_SETTING, 1024,
                                      RANDOM_SETTING, 2047, 0};
  localparam int TMO_SET [PHASES] = '{100, 0, 65535, 3, 1, 12, 0, 40};

  typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKE} rx_mode_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_req_type = REQ_BYTE;
  logic [7:0]               in_data_byte = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_status;
  logic                     out_online;
  logic signed [CHAN_W-1:0] out_channel_0;
  logic signed [CHAN_W-1:0] out_channel_1;
  logic signed [CHAN_W-1:0] out_channel_2;
  logic signed [CHAN_W-1:0] out_channel_3;
  logic signed [CHAN_W-1:0] out_channel_4;
  logic [SWB_W-1:0]         out_switches_and_buttons;
  logic signed [AXIS_W-1:0] out_mouse_x;
  logic signed [AXIS_W-1:0] out_mouse_y;
  logic signed [AXIS_W-1:0] out_mouse_z;
  logic [AXIS_W-1:0]        out_key_mask;
  logic                     cfg_we = 1'b0;
  logic                     cfg_index = REG_MIDPOINT;
  logic [CFG_W-1:0]         cfg_wdata = '0;
  int                       err_count;
  int                       pending;

  int       sent_words = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b0;
  int       idle_cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_period = 1;
  int       rx_phase = 0;

  rc_receiver_frame_decoder uut (.*);
  rcfd_checker checker_i (.*);

  always #HALF_PERIOD clk = ~clk;

  // Receiver: switch between randomly chosen stall patterns.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
      rx_period = $urandom_range(2, 6);
    end
    rx_left--;
    rx_phase = (rx_phase + 1) % rx_period;
    case (rx_mode)
      RX_OPEN:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready <= (rx_phase == 0);
      default:     out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one word, hold it until accepted, then maybe end the send burst.
  task automatic send_word(input logic [1:0] req, input logic [7:0] data);
    int gap;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_data_byte <= data;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent_words++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = gaps_on ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] mid, input logic [CFG_W-1:0] tmo);
    cfg_we <= 1'b1;
    cfg_index <= REG_MIDPOINT;
    cfg_wdata <= mid;
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Bytes of one burst; every 18th byte from offset 5 carries the switches.
  task automatic send_burst(input int n_bytes, input bit bad_switch, input bit end_idle);
    logic [7:0] v;
    int         pick;
    for (int i = 0; i < n_bytes; i++) begin
      pick = $urandom_range(0, 9);
      v = 8'($urandom);
      if (pick == 0) v = 8'h00;
      else if (pick == 1) v = 8'hFF;
      if (i % FRAME_BYTES == 5) begin
        if (bad_switch) begin
          pick = $urandom_range(0, 2);
          if (pick != 1) v[5:4] = 2'd0;
          if (pick != 0) v[7:6] = 2'd0;
        end else begin
          if (v[5:4] == 2'd0) v[5:4] = 2'($urandom_range(1, 3));
          if (v[7:6] == 2'd0) v[7:6] = 2'($urandom_range(1, 3));
        end
      end
      send_word(REQ_BYTE, v);
    end
    if (end_idle) send_word(REQ_IDLE, 8'($urandom));
  endtask

  initial begin
    int mid, tmo, pick, len;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening: empty idle, unused code, tick, short burst, all-ones frame
    send_word(REQ_IDLE, 8'h00);
    send_word(REQ_UNUSED, 8'hFF);
    send_word(REQ_TICK, 8'hA5);
    send_word(REQ_BYTE, 8'h00);
    send_word(REQ_BYTE, 8'hFF);
    send_word(REQ_IDLE, 8'h00);
    repeat (FRAME_BYTES) send_word(REQ_BYTE, 8'hFF);
    send_word(REQ_IDLE, 8'h00);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain_results();
        mid = (MID_SET[phase] == RANDOM_SETTING) ? $urandom_range(1, 2046) : MID_SET[phase];
        tmo = TMO_SET[phase];
        write_regs(CFG_W'(mid), CFG_W'(tmo));
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      while (sent_words < (phase + 1) * WORDS_PER_PHASE) begin
        pick = $urandom_range(0, 19);
        if (pick < 10) begin
          pick = $urandom_range(0, 9);
          if (pick < 5) len = FRAME_BYTES;
          else if (pick < 7) len = $urandom_range(FRAME_BYTES + 1, BUFFER_BYTES - 1);
          else if (pick == 7) len = BUFFER_BYTES;
          else if (pick == 8) len = $urandom_range(BUFFER_BYTES + 1, BUFFER_BYTES + FRAME_BYTES);
          else len = $urandom_range(1, FRAME_BYTES - 1);
          // a full buffer has already closed the burst; a following idle is ignored
          send_burst(len, $urandom_range(0, 5) == 0,
                     (len != BUFFER_BYTES) || $urandom_range(0, 1));
        end else if (pick < 14) begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 45) : $urandom_range(1, 4);
          repeat (len) send_word(REQ_TICK, 8'($urandom));
        end else if (pick < 17) begin
          send_word(2'($urandom_range(0, 3)), 8'($urandom));
        end else if (pick == 17) begin
          send_word(REQ_IDLE, 8'($urandom));
        end else if (pick == 18) begin
          drain_results();
        end else begin
          send_word(REQ_UNUSED, 8'($urandom));
        end
      end
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
